// ===== hdl/spvp_pkg.sv =====
package spvp_pkg;

	localparam int KIND_W    = 2;
	localparam int POS_W     = 32;
	localparam int VEL_W     = 17;
	localparam int RATE_W    = 16;
	localparam int CRUISE_W  = 16;
	localparam int MIN_W     = 16;
	localparam int RAMP_W    = 20;
	localparam int SLEW_W    = 16;
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 2;
	localparam int QUO_W     = 16;
	localparam int PROD_W    = CRUISE_W + RAMP_W;
	localparam int DCNT_W    = $clog2(QUO_W);

	// item kinds
	localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TARGET   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_VELOCITY = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CRUISE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLEW   = 2'd3;

	localparam logic [CRUISE_W-1:0] CRUISE_RST = 16'd2000;
	localparam logic [MIN_W-1:0]    MIN_RST    = 16'd100;
	localparam logic [RAMP_W-1:0]   RAMP_RST   = 20'd1000;
	localparam logic [SLEW_W-1:0]   SLEW_RST   = 16'd50;

	localparam int STOP_WINDOW = 5;
	localparam logic signed [VEL_W-1:0] VEL_LIMIT = 17'sd65535;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MUL,
		ST_DIV,
		ST_CMD,
		ST_SLEW,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic take;
		logic ld_diff;
		logic ld_mul;
		logic div_step;
		logic ld_cmd;
		logic ld_slew;
		logic ld_out;
	} ctrl_t;

endpackage

// ===== hdl/spvp_if.sv =====
interface spvp_item_if import spvp_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic signed [POS_W-1:0]  position_now;
	logic signed [POS_W-1:0]  target_position;
	logic signed [VEL_W-1:0]  velocity_request;

	modport source (output valid, kind, position_now, target_position, velocity_request,
		input ready);
	modport sink (input valid, kind, position_now, target_position, velocity_request,
		output ready);
endinterface

interface spvp_result_if import spvp_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [RATE_W-1:0]        step_rate;
	logic                     direction_positive;
	logic                     driver_enable;
	logic signed [VEL_W-1:0]  velocity_now;
	logic                     target_active;

	modport source (output valid, step_rate, direction_positive, driver_enable,
		velocity_now, target_active, input ready);
	modport sink (input valid, step_rate, direction_positive, driver_enable,
		velocity_now, target_active, output ready);
endinterface

// ===== hdl/stepper_position_velocity_profiler_core.sv =====
// Stepper motion profiler. Each word on the item channel is a control tick, a new
// position target, a new velocity command or a spare kind with no effect, and each
// gives exactly one result word with the slewed actual velocity, its magnitude and
// sign, the driver enable and the target flag. Items are handled one at a time and
// the item channel is not ready while one is in work. A target or velocity load goes
// straight to the output state; a tick with no target passes the slew state, one
// outside the ramp the diff, cmd and slew states, and one inside the ramp also the
// mul state and the 16-step restoring divider for cruise_speed*distance/ramp_length.
// The item channel is ready again the cycle after the result word is loaded; a
// stalled result word holds the sequencer until it is taken. Configuration must be
// written through the cfg port while no item is in work; the block does not enforce
// this. Registers reset to cruise 2000, min 100, ramp 1000 and slew 50.
module stepper_position_velocity_profiler_core
	import spvp_pkg::*;
#(
	parameter int POSITION_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	spvp_item_if.sink            item,
	spvp_result_if.source        result
);

	localparam int PB = POSITION_BITS;
	localparam int CW = (PB > RAMP_W) ? PB : RAMP_W;

	logic [CRUISE_W-1:0] cruise_q;
	logic [MIN_W-1:0]    min_q;
	logic [RAMP_W-1:0]   ramp_q;
	logic [SLEW_W-1:0]   slew_q;

	logic [PB-1:0]           target_q;
	logic [PB-1:0]           pos_q;
	logic                    tgt_act_q;
	logic signed [VEL_W-1:0] cmd_q;
	logic signed [VEL_W-1:0] act_q;
	logic                    en_q;

	logic              neg_q, inside_q, stop_q, dpos_q;
	logic [RAMP_W-1:0] mag_q;
	logic [RAMP_W-1:0] rem_q;
	logic [QUO_W-1:0]  low_q;
	logic [DCNT_W-1:0] cnt_q;

	logic                    out_valid_q;
	logic [RATE_W-1:0]       out_rate_q;
	logic                    out_dir_q;
	logic                    out_en_q;
	logic signed [VEL_W-1:0] out_vel_q;
	logic                    out_tgt_q;

	state_t state_q, state_d;
	ctrl_t  ctrl;

	logic accept, out_free, div_done;
	logic in_ramp;

	assign accept   = item.valid && item.ready;
	assign out_free = !out_valid_q || result.ready;
	assign div_done = (cnt_q == DCNT_W'(QUO_W - 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (item.kind == KIND_TICK) begin
						state_d = tgt_act_q ? ST_DIFF : ST_SLEW;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_DIFF: state_d = in_ramp ? ST_MUL : ST_CMD;
			ST_MUL:  state_d = ST_DIV;
			ST_DIV:  state_d = div_done ? ST_CMD : ST_DIV;
			ST_CMD:  state_d = ST_SLEW;
			ST_SLEW: state_d = ST_OUT;
			ST_OUT:  state_d = out_free ? ST_IDLE : ST_OUT;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE: ctrl.take     = 1'b1;
			ST_DIFF: ctrl.ld_diff  = 1'b1;
			ST_MUL:  ctrl.ld_mul   = 1'b1;
			ST_DIV:  ctrl.div_step = 1'b1;
			ST_CMD:  ctrl.ld_cmd   = 1'b1;
			ST_SLEW: ctrl.ld_slew  = 1'b1;
			ST_OUT:  ctrl.ld_out   = out_free;
			default: ctrl = '0;
		endcase
	end

	assign item.ready = ctrl.take;

	// distance to target, wrapped to the position width
	logic [PB-1:0] diff;
	logic [PB-1:0] dabs;
	logic [CW-1:0] dabs_ext;
	logic          dneg;

	assign diff     = target_q - pos_q;
	assign dneg     = diff[PB-1];
	assign dabs     = dneg ? (~diff + PB'(1)) : diff;
	assign dabs_ext = CW'(dabs);
	assign in_ramp  = dabs_ext < CW'(ramp_q);

	// velocity request saturation (only -65536 is out of range)
	logic signed [VEL_W-1:0] req_sat;
	assign req_sat = (item.velocity_request < -VEL_LIMIT) ? -VEL_LIMIT : item.velocity_request;

	// restoring divide step
	logic [RAMP_W:0] trial;
	logic            trial_ge;
	assign trial    = {rem_q, low_q[QUO_W-1]};
	assign trial_ge = trial >= {1'b0, ramp_q};

	logic [PROD_W-1:0] prod;
	assign prod = PROD_W'(cruise_q) * PROD_W'(mag_q);

	// commanded velocity from the ramp
	logic signed [VEL_W-1:0] cmd_new;
	logic [QUO_W-1:0]        q_mag;
	always_comb begin
		q_mag = (low_q <= min_q) ? min_q : low_q;
		if (stop_q) begin
			cmd_new = '0;
		end else if (inside_q) begin
			if (!neg_q || low_q == '0) begin
				cmd_new = $signed({1'b0, q_mag});
			end else begin
				cmd_new = -$signed({1'b0, q_mag});
			end
		end else if (dpos_q) begin
			cmd_new = $signed({1'b0, cruise_q});
		end else begin
			cmd_new = -$signed({1'b0, cruise_q});
		end
	end

	// slew limiter
	logic signed [VEL_W:0]   dv;
	logic [VEL_W:0]          dv_mag;
	logic signed [VEL_W:0]   act_step;
	logic signed [VEL_W-1:0] act_new;
	logic                    en_new;
	always_comb begin
		dv       = (VEL_W+1)'(cmd_q) - (VEL_W+1)'(act_q);
		dv_mag   = dv[VEL_W] ? (~dv + 1'b1) : dv;
		act_step = dv[VEL_W] ? ((VEL_W+1)'(act_q) - $signed({2'b00, slew_q}))
			: ((VEL_W+1)'(act_q) + $signed({2'b00, slew_q}));
		en_new   = !(cmd_q == '0 && act_q == '0);
		if (!en_new || dv == '0) begin
			act_new = act_q;
		end else if (dv_mag <= (VEL_W+1)'(slew_q)) begin
			act_new = cmd_q;
		end else begin
			act_new = act_step[VEL_W-1:0];
		end
	end

	logic [VEL_W-1:0] act_abs;
	assign act_abs = act_q[VEL_W-1] ? (~act_q + 1'b1) : act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cruise_q    <= CRUISE_RST;
			min_q       <= MIN_RST;
			ramp_q      <= RAMP_RST;
			slew_q      <= SLEW_RST;
			target_q    <= '0;
			tgt_act_q   <= 1'b0;
			cmd_q       <= '0;
			act_q       <= '0;
			en_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_index)
					REG_CRUISE: cruise_q <= cfg_data[CRUISE_W-1:0];
					REG_MIN:    min_q    <= cfg_data[MIN_W-1:0];
					REG_RAMP:   ramp_q   <= cfg_data[RAMP_W-1:0];
					REG_SLEW:   slew_q   <= cfg_data[SLEW_W-1:0];
					default:    ;
				endcase
			end

			if (accept) begin
				case (item.kind)
					KIND_TARGET: begin
						target_q  <= item.target_position[PB-1:0];
						tgt_act_q <= 1'b1;
					end
					KIND_VELOCITY: cmd_q <= req_sat;
					default: ;
				endcase
			end

			if (ctrl.ld_cmd) begin
				cmd_q <= cmd_new;
				if (stop_q) begin
					tgt_act_q <= 1'b0;
				end
			end

			if (ctrl.ld_slew) begin
				en_q  <= en_new;
				act_q <= act_new;
			end

			if (ctrl.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q  <= item.position_now[PB-1:0];
		end
		if (ctrl.ld_diff) begin
			neg_q    <= dneg;
			inside_q <= in_ramp;
			stop_q   <= dabs_ext <= CW'(STOP_WINDOW);
			dpos_q   <= !dneg && (diff != '0);
			mag_q    <= dabs_ext[RAMP_W-1:0];
		end
		if (ctrl.ld_mul) begin
			rem_q <= prod[PROD_W-1:QUO_W];
			low_q <= prod[QUO_W-1:0];
			cnt_q <= '0;
		end
		if (ctrl.div_step) begin
			rem_q <= trial_ge ? RAMP_W'(trial - {1'b0, ramp_q}) : trial[RAMP_W-1:0];
			low_q <= {low_q[QUO_W-2:0], trial_ge};
			cnt_q <= cnt_q + 1'b1;
		end
		if (ctrl.ld_out) begin
			out_rate_q <= act_abs[RATE_W-1:0];
			out_dir_q  <= !act_q[VEL_W-1];
			out_en_q   <= en_q;
			out_vel_q  <= act_q;
			out_tgt_q  <= tgt_act_q;
		end
	end

	assign result.valid              = out_valid_q;
	assign result.step_rate          = out_rate_q;
	assign result.direction_positive = out_dir_q;
	assign result.driver_enable      = out_en_q;
	assign result.velocity_now       = out_vel_q;
	assign result.target_active      = out_tgt_q;

endmodule

// ===== hdl/spvp_checker.sv =====
module spvp_checker
	import spvp_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [RATE_W-1:0]       step_rate,
	input logic                    direction_positive,
	input logic                    driver_enable,
	input logic signed [VEL_W-1:0] velocity_now
);

	logic [VEL_W-1:0] vel_abs;
	assign vel_abs = velocity_now[VEL_W-1] ? (~velocity_now + 1'b1) : velocity_now;

	// one word at a time: no new word right after one is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item channel ready right after a word was accepted");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(velocity_now) && $stable(step_rate))
		else $error("result word changed while stalled");

	// magnitude and sign agree with the signed velocity
	a_rate_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> vel_abs == {1'b0, step_rate}
			&& direction_positive == !velocity_now[VEL_W-1]
			&& velocity_now != {1'b1, {(VEL_W-1){1'b0}}})
		else $error("step_rate or direction does not match velocity_now");

	// driver off means the motor is standing still
	a_off_still: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !driver_enable |-> velocity_now == '0)
		else $error("driver disabled with nonzero velocity");

endmodule

bind stepper_position_velocity_profiler_core spvp_checker u_spvp_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (item.valid),
	.in_ready           (item.ready),
	.out_valid          (result.valid),
	.out_ready          (result.ready),
	.step_rate          (result.step_rate),
	.direction_positive (result.direction_positive),
	.driver_enable      (result.driver_enable),
	.velocity_now       (result.velocity_now)
);

// ===== tb/tb_stepper_position_velocity_profiler_core.sv =====
module tb_stepper_position_velocity_profiler_core;
	import spvp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam int LIMIT = 400000;

	typedef struct packed {
		logic [KIND_W-1:0]       kind;
		logic signed [POS_W-1:0] pos;
		logic signed [POS_W-1:0] tgt;
		logic signed [VEL_W-1:0] vreq;
	} cmd_word_t;

	typedef struct packed {
		logic [RATE_W-1:0]       rate;
		logic                    dir;
		logic                    en;
		logic signed [VEL_W-1:0] vel;
		logic                    tact;
	} motion_t;

	typedef struct {
		cmd_word_t w;
		bit        typed;
		motion_t   want;
	} plan_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	spvp_item_if   item_ch ();
	spvp_result_if result_ch ();

	stepper_position_velocity_profiler_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// profile registers as the block should hold them
	logic [CRUISE_W-1:0] cruise_q = CRUISE_RST;
	logic [MIN_W-1:0]    floor_q  = MIN_RST;
	logic [RAMP_W-1:0]   ramp_q   = RAMP_RST;
	logic [SLEW_W-1:0]   slew_q   = SLEW_RST;

	logic signed [POS_W-1:0] goal_q    = '0;
	logic                    goal_live = 1'b0;
	logic signed [VEL_W-1:0] vel_cmd_q = '0;
	logic signed [VEL_W-1:0] vel_act_q = '0;
	logic                    drv_en_q  = 1'b0;

	motion_t     motion_pending [$];
	plan_row_t   plan [$];
	int          errors = 0;
	int          items_sent = 0;
	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;
	bit          sending = 1'b0;
	int          cycles = 0;

	logic signed [POS_W-1:0] axis_pos = '0;

	function automatic motion_t motion_predict(input cmd_word_t w);
		logic signed [POS_W-1:0] delta;
		longint span, cmd, act, req;
		motion_t r;
		case (w.kind)
			KIND_TICK: begin
				if (goal_live) begin
					delta = goal_q - w.pos;
					span = (delta < 0) ? -longint'(delta) : longint'(delta);
					if (span < longint'(ramp_q)) begin
						cmd = longint'(cruise_q) * longint'(delta) / longint'(ramp_q);
						if (cmd >= 0 && cmd <= longint'(floor_q))
							cmd = longint'(floor_q);
						else if (cmd < 0 && cmd >= -longint'(floor_q))
							cmd = -longint'(floor_q);
					end else if (delta > 0) begin
						cmd = longint'(cruise_q);
					end else begin
						cmd = -longint'(cruise_q);
					end
					if (span <= STOP_WINDOW) begin
						goal_live = 1'b0;
						cmd = 0;
					end
					vel_cmd_q = VEL_W'(cmd);
				end
				// enable follows the velocities ahead of the slew
				cmd = longint'(vel_cmd_q);
				act = longint'(vel_act_q);
				if (cmd == 0 && act == 0) begin
					drv_en_q = 1'b0;
				end else begin
					drv_en_q = 1'b1;
					if (cmd < act)
						act = (act - cmd <= longint'(slew_q)) ? cmd : act - longint'(slew_q);
					else if (cmd > act)
						act = (cmd - act <= longint'(slew_q)) ? cmd : act + longint'(slew_q);
					vel_act_q = VEL_W'(act);
				end
			end
			KIND_TARGET: begin
				goal_q = w.tgt;
				goal_live = 1'b1;
			end
			KIND_VELOCITY: begin
				req = longint'(w.vreq);
				if (req < -longint'(VEL_LIMIT))
					req = -longint'(VEL_LIMIT);
				vel_cmd_q = VEL_W'(req);
			end
			default: ;
		endcase
		act = longint'(vel_act_q);
		r.rate = RATE_W'((act < 0) ? -act : act);
		r.dir  = (vel_act_q >= 0);
		r.en   = drv_en_q;
		r.vel  = vel_act_q;
		r.tact = goal_live;
		return r;
	endfunction

	function automatic cmd_word_t noise_word();
		cmd_word_t w;
		w.kind = KIND_W'($urandom_range(KIND_TICK, KIND_VELOCITY));
		w.pos  = $urandom;
		w.tgt  = $urandom;
		w.vreq = VEL_W'(int'($urandom_range(131070)) - 65535);
		return w;
	endfunction

	task automatic plan_add(input logic [KIND_W-1:0] kind, input logic signed [POS_W-1:0] pos,
		input logic signed [POS_W-1:0] tgt, input logic signed [VEL_W-1:0] vreq,
		input bit typed = 1'b0, input int rate = 0, input bit dir = 1'b0,
		input bit en = 1'b0, input int vel = 0, input bit tact = 1'b0);
		plan_row_t row;
		row.w.kind    = kind;
		row.w.pos     = pos;
		row.w.tgt     = tgt;
		row.w.vreq    = vreq;
		row.typed     = typed;
		row.want.rate = RATE_W'(rate);
		row.want.dir  = dir;
		row.want.en   = en;
		row.want.vel  = VEL_W'(vel);
		row.want.tact = tact;
		plan.push_back(row);
	endtask

	task automatic push_item(input cmd_word_t w, input bit typed = 1'b0,
		input motion_t fixed = '0);
		motion_t pred;
		while ($urandom_range(99) < gap_pct) begin
			if (sending) begin
				item_ch.valid <= 1'b0;
				sending = 1'b0;
			end
			@(posedge clk);
		end
		item_ch.valid            <= 1'b1;
		item_ch.kind             <= w.kind;
		item_ch.position_now     <= w.pos;
		item_ch.target_position  <= w.tgt;
		item_ch.velocity_request <= w.vreq;
		sending = 1'b1;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		pred = motion_predict(w);
		motion_pending.push_back(typed ? fixed : pred);
		items_sent++;
	endtask

	// hold the item channel until every pending result word is back
	task automatic settle(input int extra);
		if (sending) begin
			item_ch.valid <= 1'b0;
			sending = 1'b0;
		end
		while (motion_pending.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic load_profile(input logic [CFG_W-1:0] c, input logic [CFG_W-1:0] m,
		input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] s);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [CFG_W-1:0]     vals [4];
		idx  = '{REG_CRUISE, REG_MIN, REG_RAMP, REG_SLEW};
		vals = '{c, m, r, s};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			case (idx[i])
				REG_CRUISE: cruise_q = vals[i][CRUISE_W-1:0];
				REG_MIN:    floor_q  = vals[i][MIN_W-1:0];
				REG_RAMP:   ramp_q   = vals[i][RAMP_W-1:0];
				REG_SLEW:   slew_q   = vals[i][SLEW_W-1:0];
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	// set a target, mostly near the axis, then ticks that close in on it
	task automatic approach_run();
		longint off, mv;
		logic signed [POS_W-1:0] goal, d;
		cmd_word_t w;
		int n;
		case ($urandom_range(3))
			0: off = longint'($urandom_range(24)) - 12;
			1: off = longint'($urandom_range(2 * ramp_q)) - longint'(ramp_q);
			2: off = longint'($urandom_range(6 * ramp_q + 100)) - longint'(3 * ramp_q + 50);
			default: off = longint'($signed($urandom));
		endcase
		goal = axis_pos + POS_W'(off);
		w = noise_word();
		w.kind = KIND_TARGET;
		w.tgt = goal;
		push_item(w);
		n = $urandom_range(3, 24);
		for (int i = 0; i < n; i++) begin
			d = goal - axis_pos;
			if ($urandom_range(9) != 0) begin
				mv = longint'(d) * longint'($urandom_range(20, 80)) / 100;
				if (mv == 0)
					mv = longint'(d);
				axis_pos = axis_pos + POS_W'(mv);
			end
			if (i == n - 1 && $urandom_range(2) == 0)
				axis_pos = goal + POS_W'(int'($urandom_range(10)) - 5);
			else if ($urandom_range(19) == 0)
				axis_pos = axis_pos + POS_W'(int'($urandom_range(4)) - 2);
			w = noise_word();
			w.kind = KIND_TICK;
			w.pos = axis_pos;
			push_item(w);
			if ($urandom_range(15) == 0) begin
				w = noise_word();
				w.kind = KIND_VELOCITY;
				push_item(w);
			end
		end
	endtask

	task automatic command_run();
		cmd_word_t w;
		int n;
		w = noise_word();
		w.kind = KIND_VELOCITY;
		case ($urandom_range(3))
			0: w.vreq = VEL_LIMIT;
			1: w.vreq = -VEL_LIMIT;
			2: w.vreq = VEL_W'(int'($urandom_range(400)) - 200);
			default: ;
		endcase
		push_item(w);
		n = $urandom_range(1, 12);
		repeat (n) begin
			w = noise_word();
			w.kind = KIND_TICK;
			push_item(w);
		end
	endtask

	task automatic run_phase(input int quota);
		int start;
		int pick;
		start = items_sent;
		while (items_sent - start < quota) begin
			pick = $urandom_range(99);
			if (pick < 55)
				approach_run();
			else if (pick < 80)
				command_run();
			else
				push_item(noise_word());
			if ($urandom_range(49) == 0)
				settle(0);
		end
	endtask

	initial begin : result_side
		motion_t got, want;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				got.rate = result_ch.step_rate;
				got.dir  = result_ch.direction_positive;
				got.en   = result_ch.driver_enable;
				got.vel  = result_ch.velocity_now;
				got.tact = result_ch.target_active;
				if (motion_pending.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result word: rate=%0d dir=%0b en=%0b vel=%0d act=%0b",
							got.rate, got.dir, got.en, got.vel, got.tact);
				end else begin
					want = motion_pending.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10) begin
							$display("result mismatch: exp rate=%0d dir=%0b en=%0b vel=%0d act=%0b",
								want.rate, want.dir, want.en, want.vel, want.tact);
							$display("                 got rate=%0d dir=%0b en=%0b vel=%0d act=%0b",
								got.rate, got.dir, got.en, got.vel, got.tact);
						end
					end
				end
			end
			result_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin : watchdog
		while (cycles < LIMIT)
			@(posedge clk) cycles++;
		$display("[stepper_position_velocity_profiler_core] ERROR");
		$finish;
	end

	initial begin : stimulus
		int unsigned gap_mode [4];
		int unsigned stall_mode [4];
		gap_mode   = '{0, 73, 0, 10};
		stall_mode = '{0, 0, 73, 10};

		arst_n                   <= 1'b0;
		cfg_we                   <= 1'b0;
		cfg_index                <= REG_CRUISE;
		cfg_data                 <= '0;
		item_ch.valid            <= 1'b0;
		item_ch.kind             <= KIND_TICK;
		item_ch.position_now     <= '0;
		item_ch.target_position  <= '0;
		item_ch.velocity_request <= '0;

		// reset profile: cruise 2000, min 100, ramp 1000, slew 50
		plan_add(KIND_TICK, 0, 0, 0, 1, 0, 1, 0, 0, 0);
		plan_add(KIND_SPARE, -1, -1, 17'h1FFFF, 1, 0, 1, 0, 0, 0);
		plan_add(KIND_VELOCITY, 0, 0, 17'sd65535, 1, 0, 1, 0, 0, 0);
		plan_add(KIND_TICK, 0, 0, 0, 1, 50, 1, 1, 50, 0);
		plan_add(KIND_VELOCITY, 0, 0, 17'h10000, 1, 50, 1, 1, 50, 0);
		plan_add(KIND_TICK, 0, 0, 0, 1, 0, 1, 1, 0, 0);
		plan_add(KIND_TICK, 0, 0, 0, 1, 50, 0, 1, -50, 0);
		plan_add(KIND_VELOCITY, 0, 0, 0, 1, 50, 0, 1, -50, 0);
		plan_add(KIND_TICK, 0, 0, 0, 1, 0, 1, 1, 0, 0);
		plan_add(KIND_TICK, 0, 0, 0, 1, 0, 1, 0, 0, 0);
		plan_add(KIND_TARGET, 0, 10000, 0, 1, 0, 1, 0, 0, 1);
		plan_add(KIND_TICK, 0, 0, 0, 1, 50, 1, 1, 50, 1);
		plan_add(KIND_TICK, 9500, 0, 0);
		plan_add(KIND_TICK, 9990, 0, 0);
		plan_add(KIND_TICK, 9995, 0, 0);
		// distance wraps across the ends of the position range
		plan_add(KIND_TARGET, 0, 32'h8000_0000, 0);
		plan_add(KIND_TICK, 32'h7FFF_FFFF, 0, 0);
		plan_add(KIND_TARGET, 0, 32'h7FFF_FFFF, 0);
		plan_add(KIND_TICK, 32'h8000_0000, 0, 0);
		plan_add(KIND_TARGET, 0, 500, 0);
		plan_add(KIND_TICK, 0, 0, 0);
		plan_add(KIND_TARGET, 0, -500, 0);
		plan_add(KIND_TICK, 0, 0, 0);
		plan_add(KIND_VELOCITY, 0, 0, 17'sd30000);
		plan_add(KIND_TICK, -300, 0, 0);
		plan_add(KIND_TICK, -499, 0, 0);
		plan_add(KIND_TARGET, 0, 6, 0);
		plan_add(KIND_TICK, 0, 0, 0);
		plan_add(KIND_TICK, 1, 0, 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			push_item(plan[i].w, plan[i].typed, plan[i].want);
		settle(8);

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: load_profile(65535, 0, 1048575, 65535);
				1: load_profile(1, 65535, 1, 1);
				2: load_profile(3000, 200, 500, 300);
				3: load_profile(0, 0, 0, 0);
				default: load_profile($urandom_range(1, 65535), $urandom_range(0, 3000),
					$urandom_range(1, 4000), $urandom_range(1, 2000));
			endcase
			gap_pct   = gap_mode[p % 4];
			stall_pct = stall_mode[p % 4];
			run_phase((p == 3) ? 40 : 100);
			settle(8);
		end

		gap_pct = 0;
		stall_pct = 0;
		repeat (30) @(posedge clk);
		errors += motion_pending.size();
		if (errors == 0)
			$display("[stepper_position_velocity_profiler_core] OK");
		else
			$display("[stepper_position_velocity_profiler_core] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/spvp_pkg.sv
hdl/spvp_if.sv
hdl/stepper_position_velocity_profiler_core.sv
hdl/spvp_checker.sv
tb/tb_stepper_position_velocity_profiler_core.sv
